/* hw/rtl/h2f_pkg.sv */
// Shared types, constants and helper functions of the hash-to-field block.
// No dependencies; every module of the block and the testbench import this package.
package h2f_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = 2;

   localparam int FIN_PREFIX_LEN = 44;
   localparam logic [5:0] FIN_PREFIX_END = 6'(FIN_PREFIX_LEN - 1);
   localparam logic [6:0] LEN_FIELD_POS = 7'd112;
   localparam logic [6:0] BLOCK_LAST = 7'd127;
   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam logic [3:0] LEN_BYTE_LAST = 4'd15;
   // bytes added after the message (44) plus the leading zero block (128)
   localparam int LEN_OFFSET = 172;
   localparam logic [6:0] LAST_ROUND = 7'd79;
   localparam logic [1:0] LAST_LIMB = 2'd3;

   typedef logic [0:7][63:0] digest_type;

   typedef struct packed {
      logic [7:0] msg_byte;
      logic has_byte;
      logic last;
   } item_type;

   typedef struct packed {
      logic load_init;
      logic load_b1;
      logic start;
      logic wr_en;
      logic [6:0] wr_idx;
      logic [7:0] wr_byte;
   } core_ctl_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_INIT_GO,
      ST_RUN,
      ST_FIN_SETUP,
      ST_FIN,
      ST_B1,
      ST_B1_GO,
      ST_RED_GO,
      ST_WAIT,
      ST_OUT
   } back_state_type;

   typedef enum logic [1:0] {
      PH_PREFIX,
      PH_PAD,
      PH_ZERO,
      PH_LENGTH
   } fin_phase_type;

   typedef enum logic [1:0] {
      RS_SUM,
      RS_FOLD_A,
      RS_FOLD_B,
      RS_CANON
   } red_step_type;

   localparam digest_type SHA_IV = {
      64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
      64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};

   // Second half of the b1 block: 0x01, tag, 0x04, 0x28, pad, bit length 848.
   localparam digest_type B1_TAIL = {
      64'h0145435652465f65,
      64'h6477617264733235, 64'h3531395f584d443a, 64'h5348412d3531325f,
      64'h454c4c325f4e555f, 64'h0428800000000000, 64'h0000000000000000,
      64'h0000000000000350};

   localparam logic [7:0] FIN_PREFIX [FIN_PREFIX_LEN] = '{
      8'h00, 8'h30, 8'h00, 8'h45, 8'h43, 8'h56, 8'h52, 8'h46, 8'h5f, 8'h65, 8'h64,
      8'h77, 8'h61, 8'h72, 8'h64, 8'h73, 8'h32, 8'h35, 8'h35, 8'h31, 8'h39, 8'h5f,
      8'h58, 8'h4d, 8'h44, 8'h3a, 8'h53, 8'h48, 8'h41, 8'h2d, 8'h35, 8'h31, 8'h32,
      8'h5f, 8'h45, 8'h4c, 8'h4c, 8'h32, 8'h5f, 8'h4e, 8'h55, 8'h5f, 8'h04, 8'h28};

   localparam logic [63:0] SHA_K [80] = '{
      64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
      64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
      64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
      64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
      64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
      64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
      64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
      64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
      64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
      64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
      64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
      64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
      64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
      64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
      64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
      64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
      64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
      64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
      64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
      64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};

   function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
      return (x >> n) | (x << (64 - n));
   endfunction

   function automatic logic [63:0] big_sigma0(input logic [63:0] x);
      return rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
   endfunction

   function automatic logic [63:0] big_sigma1(input logic [63:0] x);
      return rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
   endfunction

   function automatic logic [63:0] small_sigma0(input logic [63:0] x);
      return rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
   endfunction

   function automatic logic [63:0] small_sigma1(input logic [63:0] x);
      return rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
   endfunction

endpackage

/* hw/rtl/h2f_req_if.sv */
// Request channel of the hash-to-field block: one message item per transfer.
// No dependencies.
interface h2f_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] msg_byte;
   logic       has_byte;
   logic       last;

   modport source (output valid, msg_byte, has_byte, last, input ready);
   modport sink (input valid, msg_byte, has_byte, last, output ready);
endinterface

/* hw/rtl/h2f_rsp_if.sv */
// Response channel of the hash-to-field block: one 64-bit limb per transfer.
// No dependencies.
interface h2f_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] limb_value;
   logic [1:0]  limb_index;
   logic        last_limb;
   logic        too_long;

   modport source (output valid, limb_value, limb_index, last_limb, too_long, input ready);
   modport sink (input valid, limb_value, limb_index, last_limb, too_long, output ready);
endinterface

/* hw/rtl/h2f_front.sv */
// Front end: takes request transfers, drops idle items, queues the rest.
// Depends on h2f_pkg and h2f_req_if.
module h2f_front import h2f_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   h2f_req_if.sink  req,
   output logic     q_valid,
   output item_type q_item,
   input  logic     q_pop
);

   item_type q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   fill_ff, fill_in;
   logic push, pop;

   assign req.ready = (fill_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign q_valid   = (fill_ff != '0);
   assign q_item    = q_ff[rd_ptr_ff];

   // keep only items that carry a byte or end the message
   assign push = req.valid & req.ready & (req.has_byte | req.last);
   assign pop  = q_pop & q_valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= '{msg_byte: req.msg_byte, has_byte: req.has_byte, last: req.last};
      end
   end

endmodule

/* hw/rtl/h2f_sha_core.sv */
// SHA-512 compression unit: 16-word block window, one round per cycle.
// Depends on h2f_pkg.
module h2f_sha_core import h2f_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  core_ctl_type ctl,
   output logic         busy,
   output digest_type   chain
);

   logic [63:0] w_ff [16];
   digest_type  chain_ff, v_ff;
   logic [6:0]  round_ff, round_in;
   logic        busy_ff, busy_in, add_ff, add_in;
   logic        round_active;
   logic [63:0] t1, t2, w_new;
   logic [5:0]  lane_sel;

   assign busy  = busy_ff;
   assign chain = chain_ff;
   assign round_active = busy_ff & ~add_ff;
   assign lane_sel = {3'd7 - ctl.wr_idx[2:0], 3'b000};

   always_comb begin
      t1 = v_ff[7] + big_sigma1(v_ff[4]) + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
         + SHA_K[round_ff] + w_ff[0];
      t2 = big_sigma0(v_ff[0])
         + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
      w_new = w_ff[0] + small_sigma0(w_ff[1]) + w_ff[9] + small_sigma1(w_ff[14]);
   end

   always_comb begin
      busy_in  = busy_ff;
      add_in   = add_ff;
      round_in = round_ff;
      if (ctl.start) begin
         busy_in  = 1'b1;
         add_in   = 1'b0;
         round_in = '0;
      end else if (add_ff) begin
         busy_in = 1'b0;
         add_in  = 1'b0;
      end else if (busy_ff) begin
         round_in = round_ff + 1'b1;
         if (round_ff == LAST_ROUND) begin
            add_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         add_ff   <= 1'b0;
         round_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         add_ff   <= add_in;
         round_ff <= round_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_init) begin
         chain_ff <= SHA_IV;
         for (int j = 0; j < 16; j++) begin
            w_ff[j] <= '0;
         end
      end else if (ctl.load_b1) begin
         // b0 into the first half, fixed suffix into the second
         for (int j = 0; j < 8; j++) begin
            w_ff[j]     <= chain_ff[j];
            w_ff[j + 8] <= B1_TAIL[j];
         end
         chain_ff <= SHA_IV;
      end else begin
         if (ctl.wr_en) begin
            w_ff[ctl.wr_idx[6:3]][lane_sel +: 8] <= ctl.wr_byte;
         end
         if (round_active) begin
            for (int j = 0; j < 15; j++) begin
               w_ff[j] <= w_ff[j + 1];
            end
            w_ff[15] <= w_new;
            v_ff[0]  <= t1 + t2;
            v_ff[1]  <= v_ff[0];
            v_ff[2]  <= v_ff[1];
            v_ff[3]  <= v_ff[2];
            v_ff[4]  <= v_ff[3] + t1;
            v_ff[5]  <= v_ff[4];
            v_ff[6]  <= v_ff[5];
            v_ff[7]  <= v_ff[6];
         end
         if (add_ff) begin
            for (int j = 0; j < 8; j++) begin
               chain_ff[j] <= chain_ff[j] + v_ff[j];
            end
         end
      end
      if (ctl.start) begin
         v_ff <= chain_ff;
      end
   end

endmodule

/* hw/rtl/h2f_reduce.sv */
// Reduction of a 384-bit big-endian value modulo 2^255-19, four steps.
// Depends on h2f_pkg.
module h2f_reduce import h2f_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [383:0] value,
   output logic         busy,
   output logic [255:0] result
);

   red_step_type step_ff, step_in;
   logic         busy_ff, busy_in;
   logic [255:0] lo_ff;
   logic [133:0] m_ff, m_calc;
   logic [256:0] acc_ff, acc_in;
   logic [6:0]   fold_add;
   logic [255:0] canon_try;

   assign busy   = busy_ff;
   assign result = acc_ff[255:0];

   always_comb begin
      // high 128 bits times 38 (2^256 is 38 mod p)
      m_calc = {value[383:256], 5'b0} + {3'b0, value[383:256], 2'b0}
             + {4'b0, value[383:256], 1'b0};
      // bits at 2^255 and above fold back times 19
      fold_add  = 7'({acc_ff[256:255], 4'b0}) + 7'({acc_ff[256:255], 1'b0})
                + 7'(acc_ff[256:255]);
      canon_try = {1'b0, acc_ff[254:0]} + 256'(19);
   end

   always_comb begin
      step_in = step_ff;
      busy_in = busy_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = RS_SUM;
      end else if (busy_ff) begin
         unique case (step_ff)
            RS_SUM: begin
               acc_in  = {1'b0, lo_ff} + 257'(m_ff);
               step_in = RS_FOLD_A;
            end
            RS_FOLD_A: begin
               acc_in  = {2'b0, acc_ff[254:0]} + 257'(fold_add);
               step_in = RS_FOLD_B;
            end
            RS_FOLD_B: begin
               acc_in  = {2'b0, acc_ff[254:0]} + 257'(fold_add);
               step_in = RS_CANON;
            end
            RS_CANON: begin
               acc_in  = canon_try[255] ? {2'b0, canon_try[254:0]} : {2'b0, acc_ff[254:0]};
               busy_in = 1'b0;
            end
            default: begin
               step_in = RS_SUM;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= RS_SUM;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (start) begin
         lo_ff <= value[255:0];
         m_ff  <= m_calc;
      end
   end

endmodule

/* hw/rtl/h2f_back.sv */
// Back end: absorbs queued bytes, runs the xmd finishing sequence and the
// second hash, drives the reducer and the response channel.
// Depends on h2f_pkg and h2f_rsp_if.
module h2f_back import h2f_pkg::*; #(
   parameter int LEN_BITS = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          q_valid,
   input  item_type      q_item,
   output logic          q_pop,
   output core_ctl_type  core_ctl,
   input  logic          core_busy,
   input  logic          red_busy,
   output logic          red_start,
   input  logic [255:0]  red_result,
   h2f_rsp_if.source     rsp
);

   back_state_type state_ff, state_in, ret_ff, ret_in;
   fin_phase_type  phase_ff, phase_in;
   logic [LEN_BITS-1:0] count_ff, count_in;
   logic [LEN_BITS:0]   total_ff, total_in;
   logic [5:0] k_ff, k_in;
   logic [1:0] limb_ff, limb_in;
   logic       ovf_ff, ovf_in;
   logic [6:0] idx;
   logic       fin_wr;
   logic [7:0] fin_byte;
   logic [127:0] len_field;

   assign idx       = count_ff[6:0];
   assign len_field = 128'({total_ff, 3'b000});
   assign fin_wr    = !(phase_ff == PH_ZERO && idx == LEN_FIELD_POS);

   always_comb begin
      unique case (phase_ff)
         PH_PREFIX: fin_byte = FIN_PREFIX[k_ff];
         PH_PAD:    fin_byte = PAD_BYTE;
         PH_ZERO:   fin_byte = '0;
         PH_LENGTH: fin_byte = len_field[{LEN_BYTE_LAST - k_ff[3:0], 3'b000} +: 8];
         default:   fin_byte = '0;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      unique case (state_ff)
         ST_INIT:    state_in = ST_INIT_GO;
         ST_INIT_GO: begin
            state_in = ST_WAIT;
            ret_in   = ST_RUN;
         end
         ST_RUN: begin
            if (q_valid) begin
               if (q_item.has_byte && idx == BLOCK_LAST) begin
                  state_in = ST_WAIT;
                  ret_in   = q_item.last ? ST_FIN_SETUP : ST_RUN;
               end else if (q_item.last) begin
                  state_in = ST_FIN_SETUP;
               end
            end
         end
         ST_FIN_SETUP: state_in = ST_FIN;
         ST_FIN: begin
            if (fin_wr && idx == BLOCK_LAST) begin
               state_in = ST_WAIT;
               ret_in   = (phase_ff == PH_LENGTH) ? ST_B1 : ST_FIN;
            end
         end
         ST_B1:    state_in = ST_B1_GO;
         ST_B1_GO: begin
            state_in = ST_WAIT;
            ret_in   = ST_RED_GO;
         end
         ST_RED_GO: begin
            state_in = ST_WAIT;
            ret_in   = ST_OUT;
         end
         ST_WAIT: begin
            if (!core_busy && !red_busy) begin
               state_in = ret_ff;
            end
         end
         ST_OUT: begin
            if (rsp.ready && limb_ff == LAST_LIMB) begin
               state_in = ST_INIT;
            end
         end
         default: state_in = ST_INIT;
      endcase
   end

   // outputs
   always_comb begin
      core_ctl  = '0;
      q_pop     = 1'b0;
      red_start = 1'b0;
      rsp.valid = 1'b0;
      unique case (state_ff)
         ST_INIT:    core_ctl.load_init = 1'b1;
         ST_INIT_GO: core_ctl.start = 1'b1;
         ST_B1:      core_ctl.load_b1 = 1'b1;
         ST_B1_GO:   core_ctl.start = 1'b1;
         ST_RED_GO:  red_start = 1'b1;
         ST_RUN: begin
            q_pop = q_valid;
            if (q_valid && q_item.has_byte) begin
               core_ctl.wr_en   = 1'b1;
               core_ctl.wr_idx  = idx;
               core_ctl.wr_byte = q_item.msg_byte;
               core_ctl.start   = (idx == BLOCK_LAST);
            end
         end
         ST_FIN: begin
            core_ctl.wr_en   = fin_wr;
            core_ctl.wr_idx  = idx;
            core_ctl.wr_byte = fin_byte;
            core_ctl.start   = fin_wr && idx == BLOCK_LAST;
         end
         ST_OUT: rsp.valid = 1'b1;
         default: ;
      endcase
   end

   assign rsp.limb_value = red_result[{limb_ff, 6'b000000} +: 64];
   assign rsp.limb_index = limb_ff;
   assign rsp.last_limb  = (limb_ff == LAST_LIMB);
   assign rsp.too_long   = ovf_ff;

   // counters and finishing sequence
   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      total_in = total_ff;
      phase_in = phase_ff;
      k_in     = k_ff;
      limb_in  = limb_ff;
      unique case (state_ff)
         ST_RUN: begin
            if (q_valid && q_item.has_byte) begin
               count_in = count_ff + 1'b1;
               if (&count_ff) begin
                  ovf_in = 1'b1;
               end
            end
         end
         ST_FIN_SETUP: begin
            total_in = {1'b0, count_ff} + (LEN_BITS+1)'(LEN_OFFSET);
            phase_in = PH_PREFIX;
            k_in     = '0;
         end
         ST_FIN: begin
            if (fin_wr) begin
               count_in = count_ff + 1'b1;
            end
            unique case (phase_ff)
               PH_PREFIX: begin
                  k_in = k_ff + 1'b1;
                  if (k_ff == FIN_PREFIX_END) begin
                     phase_in = PH_PAD;
                     k_in     = '0;
                  end
               end
               PH_PAD: phase_in = PH_ZERO;
               PH_ZERO: begin
                  if (idx == LEN_FIELD_POS) begin
                     phase_in = PH_LENGTH;
                  end
               end
               PH_LENGTH: k_in = k_ff + 1'b1;
               default: phase_in = PH_PREFIX;
            endcase
         end
         ST_OUT: begin
            if (rsp.ready) begin
               limb_in = limb_ff + 1'b1;
               if (limb_ff == LAST_LIMB) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         ret_ff   <= ST_RUN;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         phase_ff <= PH_PREFIX;
         k_ff     <= '0;
         limb_ff  <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         phase_ff <= phase_in;
         k_ff     <= k_in;
         limb_ff  <= limb_in;
      end
   end

   always_ff @(posedge clock) begin
      total_ff <= total_in;
   end

endmodule

/* hw/rtl/hash_to_field_sha512_p25519_unit.sv */
// Hash-to-field, XMD message expansion over SHA-512, result reduced mod 2^255-19.
// Each message byte is absorbed in turn; every 128th byte starts a
// compression. Finishing writes 61 to 188 bytes and runs 2 or 3
// compressions, a reduction, 4 limb transfers and a re-seed pass. Reset is
// synchronous; after it the re-seed pass runs before the first byte is
// absorbed, while the front queue already takes transfers.
module hash_to_field_sha512_p25519_unit import h2f_pkg::*; #(
   parameter int LEN_BITS = 32
) (
   input logic       clock,
   input logic       reset,
   h2f_req_if.sink   req_ch,
   h2f_rsp_if.source rsp_ch
);

   // front end to back end: queued items that carry a byte or end a message
   logic         q_valid;
   item_type     q_item;
   logic         q_pop;

   // back end to compression unit and reducer
   core_ctl_type core_ctl;
   logic         core_busy;
   digest_type   chain;
   logic         red_start;
   logic         red_busy;
   logic [255:0] red_result;

   // Front: drop idle items, hold up to four items so requests keep moving
   // while the back end compresses.
   h2f_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .q_valid (q_valid),
      .q_item  (q_item),
      .q_pop   (q_pop)
   );

   // Compression unit: one round per cycle, 80 rounds plus the chain add.
   h2f_sha_core u_core (
      .clock (clock),
      .reset (reset),
      .ctl   (core_ctl),
      .busy  (core_busy),
      .chain (chain)
   );

   // Reducer takes the first 48 bytes of b1 as a big-endian number.
   h2f_reduce u_reduce (
      .clock  (clock),
      .reset  (reset),
      .start  (red_start),
      .value  ({chain[0], chain[1], chain[2], chain[3], chain[4], chain[5]}),
      .busy   (red_busy),
      .result (red_result)
   );

   // Back end: absorb, pad, hash b0 then b1, reduce, transfer four limbs.
   h2f_back #(
      .LEN_BITS (LEN_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .core_ctl   (core_ctl),
      .core_busy  (core_busy),
      .red_busy   (red_busy),
      .red_start  (red_start),
      .red_result (red_result),
      .rsp        (rsp_ch)
   );

`ifndef ASSERT_OFF
   // limbs of one result advance one by one without a gap
   a_limb_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready && !rsp_ch.last_limb) |=>
      (rsp_ch.valid && rsp_ch.limb_index == $past(rsp_ch.limb_index) + 2'd1))
      else $error("limb sequence broken");

   // a new result always opens with limb 0
   a_limb_start: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> (rsp_ch.limb_index == 2'd0))
      else $error("result does not start at limb 0");

   // the overflow flag holds across the limbs of one result
   a_flag_steady: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready && !rsp_ch.last_limb) |=> $stable(rsp_ch.too_long))
      else $error("too_long changed within a result");

   // the compression unit is never started while it is still running
   a_core_start: assert property (@(posedge clock) disable iff (reset)
      core_ctl.start |-> !core_busy)
      else $error("compression restarted while busy");
`endif

endmodule

/* tb/sv/tb_hash_to_field_sha512_p25519_unit.sv */
// Self-checking testbench of hash_to_field_sha512_p25519_unit: random messages in, limbs checked.
// Depends on h2f_pkg, the h2f_req_if / h2f_rsp_if channel interfaces and the unit under test.
module tb_hash_to_field_sha512_p25519_unit;
   import h2f_pkg::*;

   localparam int CLOCK_HIGH = 4;
   localparam int CLOCK_LOW = 4;
   localparam int RESET_CYCLES = 10;
   localparam int CYCLE_LIMIT = 900000;
   localparam int ITEM_TARGET = 460;
   localparam int HOLD_CYCLES = 1500;
   localparam int DRAIN_CYCLES = 400;
   localparam logic [254:0] FIELD_PRIME = (255'd1 << 255) - 255'd19;

   // Expected limb store plus its own hash-to-field model.
   class limb_scoreboard;
      typedef struct packed {
         logic [63:0] value;
         logic [1:0]  index;
         logic        last_limb;
         logic        too_long;
      } limb_type;

      limb_type expected_limbs[$];
      digest_type chain;
      logic [7:0] blk[128];
      logic [31:0] count;
      bit wrapped;
      longint unsigned pos;
      int unsigned hashes_done;

      function new();
         restart();
      endfunction

      function logic [63:0] ror(logic [63:0] x, int unsigned n);
         return (x >> n) | (x << (64 - n));
      endfunction

      function digest_type compress(digest_type h, logic [7:0] b[128]);
         logic [63:0] w[80];
         logic [63:0] v[8];
         logic [63:0] t1, t2, s0, s1;
         digest_type r;
         for (int i = 0; i < 16; i++) begin
            w[i] = '0;
            for (int j = 0; j < 8; j++) w[i] = {w[i][55:0], b[i*8+j]};
         end
         for (int i = 16; i < 80; i++) begin
            s0 = ror(w[i-15], 1) ^ ror(w[i-15], 8) ^ (w[i-15] >> 7);
            s1 = ror(w[i-2], 19) ^ ror(w[i-2], 61) ^ (w[i-2] >> 6);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
         end
         for (int i = 0; i < 8; i++) v[i] = h[i];
         for (int i = 0; i < 80; i++) begin
            t1 = v[7] + (ror(v[4], 14) ^ ror(v[4], 18) ^ ror(v[4], 41))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[i] + w[i];
            t2 = (ror(v[0], 28) ^ ror(v[0], 34) ^ ror(v[0], 39))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
         end
         for (int i = 0; i < 8; i++) r[i] = h[i] + v[i];
         return r;
      endfunction

      // Seed the chain with the leading all-zero block.
      function void restart();
         for (int i = 0; i < 128; i++) blk[i] = 8'h00;
         chain = compress(SHA_IV, blk);
         count = '0;
         wrapped = 0;
      endfunction

      function void absorb(logic [7:0] b);
         blk[pos[6:0]] = b;
         if (pos[6:0] == BLOCK_LAST) chain = compress(chain, blk);
         pos++;
      endfunction

      function void finish_message();
         longint unsigned total;
         digest_type b0, b1;
         logic [383:0] wide;
         logic [254:0] residue;
         logic [7:0] b1_blk[128];
         limb_type e;
         pos = count;
         for (int i = 0; i < FIN_PREFIX_LEN; i++) absorb(FIN_PREFIX[i]);
         total = pos + 128;
         absorb(PAD_BYTE);
         while (pos[6:0] != LEN_FIELD_POS) absorb(8'h00);
         for (int i = 7; i >= 0; i--) absorb(8'(total >> (61 + 8 * i)));
         for (int i = 7; i >= 0; i--) absorb(8'((total << 3) >> (8 * i)));
         b0 = chain;
         for (int i = 0; i < 128; i++) b1_blk[i] = 8'h00;
         for (int i = 0; i < 8; i++)
            for (int j = 0; j < 8; j++) b1_blk[i*8+j] = b0[i][63-8*j -: 8];
         b1_blk[64] = 8'h01;
         // tag, 0x04 and the tag length follow the three-byte lead of the prefix
         for (int i = 3; i < FIN_PREFIX_LEN; i++) b1_blk[62+i] = FIN_PREFIX[i];
         b1_blk[106] = PAD_BYTE;
         b1_blk[126] = 8'h03;
         b1_blk[127] = 8'h50;
         b1 = compress(SHA_IV, b1_blk);
         wide = {b1[0], b1[1], b1[2], b1[3], b1[4], b1[5]};
         residue = 255'(wide % {129'd0, FIELD_PRIME});
         for (int k = 0; k < 4; k++) begin
            e = '{64'({1'b0, residue} >> (64 * k)), 2'(k), k == 3, wrapped};
            expected_limbs.insert(expected_limbs.size(), e);
         end
         hashes_done++;
         restart();
      endfunction

      function void note_item(item_type it);
         if (it.has_byte) begin
            pos = count;
            absorb(it.msg_byte);
            if (count == '1) begin
               wrapped = 1;
               count = '0;
            end else begin
               count++;
            end
         end
         if (it.last) finish_message();
      endfunction

      function string check_limb(logic [63:0] value, logic [1:0] index,
                                 logic last_limb, logic too_long);
         limb_type e;
         if (expected_limbs.size() == 0)
            return $sformatf("unexpected limb %0d value %h", index, value);
         e = expected_limbs.pop_front();
         if (value !== e.value || index !== e.index || last_limb !== e.last_limb
             || too_long !== e.too_long)
            return $sformatf("limb got %h/%0d/%b/%b expected %h/%0d/%b/%b",
                             value, index, last_limb, too_long,
                             e.value, e.index, e.last_limb, e.too_long);
         return "";
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   h2f_req_if req_ch();
   h2f_rsp_if rsp_ch();

   limb_scoreboard limb_sb = new();
   int error_count = 0;
   int cycle_count = 0;
   int items_sent = 0;
   int limbs_seen = 0;
   bit calm = 0;          // no random idling while set
   int hold_requests = 0;  // bumped by the sender to ask for a long receiver hold
   int hold_served = 0;
   int hold_left = 0;

   hash_to_field_sha512_p25519_unit u_dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source)
   );

   always begin
      #CLOCK_HIGH clock = 1;
      #CLOCK_LOW clock = 0;
   end

   task automatic report(string text);
      $display("mismatch at cycle %0d: %s", cycle_count, text);
      error_count++;
   endtask

   // Watchdog: end the run as failed once the cycle count passes the limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("== FAIL ==");
         $finish;
      end
   end

   // Monitor both channels with pre-edge values.
   always @(posedge clock) begin
      string msg;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            limb_sb.note_item('{req_ch.msg_byte, req_ch.has_byte, req_ch.last});
         if (rsp_ch.valid && rsp_ch.ready) begin
            limbs_seen++;
            msg = limb_sb.check_limb(rsp_ch.limb_value, rsp_ch.limb_index,
                                     rsp_ch.last_limb, rsp_ch.too_long);
            if (msg != "") report(msg);
         end
      end
   end

   // Receiver: random stalls, plus a long hold on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_requests != hold_served) begin
         hold_served = hold_requests;
         hold_left = HOLD_CYCLES;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= calm || ($urandom_range(99) >= 10);
      end
   end

   // Hold one item on the request channel until it transfers.
   task automatic send_item(logic [7:0] b, logic has, logic fin);
      if (!calm && $urandom_range(99) < 10) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.msg_byte <= b;
      req_ch.has_byte <= has;
      req_ch.last <= fin;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
   endtask

   // Random message: random bytes, occasional idle items, random way of ending.
   task automatic send_message(int len);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(99) < 5) send_item(8'($urandom), 1'b0, 1'b0);
         send_item(8'($urandom), 1'b1, (i == len - 1) && ($urandom_range(1) == 1));
      end
      if (!req_ch.last || len == 0) send_item(8'($urandom), 1'b0, 1'b1);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (limb_sb.expected_limbs.size() != 0) @(posedge clock);
   endtask

   initial begin
      int len;
      int sel;
      int calm_from;
      bit paused;
      calm_from = 0;
      paused = 0;
      req_ch.valid = 1'b0;
      req_ch.msg_byte = '0;
      req_ch.has_byte = 1'b0;
      req_ch.last = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty message, extreme bytes, idle item, finish without byte.
      send_item(8'hFF, 1'b0, 1'b1);
      send_item(8'h00, 1'b1, 1'b1);
      send_item(8'hFF, 1'b1, 1'b1);
      send_item(8'hA5, 1'b0, 1'b0);
      send_item(8'h5A, 1'b1, 1'b0);
      send_item(8'h00, 1'b0, 1'b0);
      send_item(8'hFF, 1'b1, 1'b0);
      send_item(8'h3C, 1'b0, 1'b1);

      // Random messages; lengths chosen so padding lands on both sides of
      // the length field and a few messages span several blocks.
      while (items_sent < ITEM_TARGET) begin
         sel = $urandom_range(99);
         if (sel < 60) len = $urandom_range(0, 20);
         else if (sel < 85) len = $urandom_range(60, 90);
         else len = $urandom_range(120, 270);
         if (len > ITEM_TARGET - items_sent) len = ITEM_TARGET - items_sent;
         // one stretch of about a hundred items without any idling
         if (!calm && calm_from == 0 && items_sent > 180) begin
            calm = 1;
            calm_from = items_sent;
         end else if (calm && items_sent > calm_from + 100) begin
            calm = 0;
         end
         if (hold_requests == 0 && items_sent > 100) begin
            // fill the block while the receiver sits still
            hold_requests++;
            send_message(20);
            send_message(5);
         end else if (!paused && items_sent > 150) begin
            // sender pause until the block has delivered everything
            paused = 1;
            wait_drained();
            send_message(len);
         end else begin
            send_message(len);
         end
      end
      calm = 0;

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d items sent, %0d messages hashed, %0d limbs checked",
               items_sent, limb_sb.hashes_done, limbs_seen);
      $display("covered empty, single-byte, multi-block and idle-padded messages");
      if (error_count == 0 && limb_sb.expected_limbs.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches, %0d limbs missing", error_count,
                  limb_sb.expected_limbs.size());
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
